@@ rtl/bmd_pkg.sv @@
// Shared types and constants of the BER message deframer.
package bmd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CONTENT_W = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_TAG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DONE_TAG    = 1'b1;

    localparam logic [BYTE_W-1:0] MESSAGE_TAG_RESET = 8'h30;
    localparam logic [BYTE_W-1:0] DONE_TAG_RESET    = 8'h65;
    localparam logic [BYTE_W-1:0] TAG_INTEGER       = 8'h02;

    typedef enum logic [1:0] {
        OP_TAG  = 2'd0,
        OP_LEN0 = 2'd1,
        OP_LENX = 2'd2,
        OP_BODY = 2'd3
    } t_outer_phase;

    typedef enum logic [2:0] {
        IP_ID_TAG  = 3'd0,
        IP_ID_LEN0 = 3'd1,
        IP_ID_LENX = 3'd2,
        IP_ID_SKIP = 3'd3,
        IP_OP_TAG  = 3'd4,
        IP_IDLE    = 3'd5
    } t_inner_phase;

    typedef enum logic [1:0] {
        ROLE_TAG     = 2'd0,
        ROLE_LENGTH  = 2'd1,
        ROLE_CONTENT = 2'd2
    } t_byte_role;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_INDEFINITE = 2'd1,
        ERR_LEN_LONG   = 2'd2
    } t_error_code;

endpackage

@@ rtl/bmd_if.sv @@
// Valid/ready channel interfaces for received bytes and deframer results.
interface bmd_rx_if
    import bmd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bmd_res_if
    import bmd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] echo_byte;
    logic [1:0]        byte_role;
    logic              frame_last;
    logic [BYTE_W-1:0] op_tag;
    logic              op_valid;
    logic              search_done;
    logic [1:0]        error_code;

    modport source (output valid, output echo_byte, output byte_role, output frame_last,
                    output op_tag, output op_valid, output search_done,
                    output error_code, input ready);
    modport sink   (input valid, input echo_byte, input byte_role, input frame_last,
                    input op_tag, input op_valid, input search_done,
                    input error_code, output ready);
endinterface

@@ rtl/ber_message_deframer.sv @@
// Top level of the BER tag-length-value message deframer.
//
//   Channel   Direction  Payload                                   Transaction
//   i_rx      in         rx_byte                                   valid & ready
//   o_res     out        echo_byte, byte_role, frame_last, op_tag, valid & ready
//                        op_valid, search_done, error_code
//   i_cfg_*   in         index, data (message_tag, done_tag)       i_cfg_we
//
// Every received byte produces exactly one result. A byte is held in the input
// register, is decoded by the framing logic and is written to the result
// register once that register is free, so one byte can be taken every cycle
// while the sink keeps ready high. The decode path is bounded by the 32-bit
// content decrement and its zero test. When the result register is full and
// the sink stalls, the input register still takes one more byte, and input
// ready falls only when both registers hold a transaction. Reset (synchronous,
// active low) empties both registers, returns framing to the tag byte and
// restores the configuration registers to their reset tags.
module ber_message_deframer
    import bmd_pkg::*;
#(
    parameter int unsigned MAX_LEN_BYTES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bmd_rx_if.sink                i_rx,
    bmd_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Width of the length-byte counters; they must hold MAX_LEN_BYTES itself.
    localparam int unsigned LW = $clog2(MAX_LEN_BYTES + 1);
    localparam logic [6:0] MAX_LEN_7 = 7'(MAX_LEN_BYTES);
    localparam logic [LW-1:0] LW_ONE = LW'(1);

    // Configuration registers.
    logic [BYTE_W-1:0] r_message_tag;
    logic [BYTE_W-1:0] r_done_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_message_tag <= MESSAGE_TAG_RESET;
            r_done_tag    <= DONE_TAG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MESSAGE_TAG: r_message_tag <= i_cfg_data;
                CFG_DONE_TAG:    r_done_tag    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline handshake: the input register advances whenever the result
    // register is empty or is being drained in this cycle.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic              advance;
    logic              step;

    assign advance    = !r_out_valid || o_res.ready;
    assign step       = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Framing state: the outer state machine walks tag, length and content;
    // the inner one parses the message-ID INTEGER inside the content and
    // catches the operation tag that follows it.
    t_outer_phase         r_outer, n_outer;
    logic [LW-1:0]        r_len_left, n_len_left;
    logic [CONTENT_W-1:0] r_content, n_content;
    logic                 r_tag_ok, n_tag_ok;
    t_inner_phase         r_inner, n_inner;
    logic [CONTENT_W-1:0] r_id_acc, n_id_acc;
    logic [LW-1:0]        r_id_left, n_id_left;
    logic [BYTE_W-1:0]    r_cap_op, n_cap_op;
    logic                 r_op_found, n_op_found;

    // Result of the byte in the input register.
    t_byte_role        s_role;
    t_error_code       s_err;
    logic              s_last;
    logic              s_finish;
    logic              s_clear;
    logic [BYTE_W-1:0] s_op_tag;
    logic              s_op_valid;
    logic              s_done;
    logic [6:0]        s_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer    <= OP_TAG;
            r_len_left <= '0;
            r_content  <= '0;
            r_tag_ok   <= 1'b0;
            r_inner    <= IP_ID_TAG;
            r_id_acc   <= '0;
            r_id_left  <= '0;
            r_cap_op   <= '0;
            r_op_found <= 1'b0;
        end else if (step) begin
            r_outer    <= n_outer;
            r_len_left <= n_len_left;
            r_content  <= n_content;
            r_tag_ok   <= n_tag_ok;
            r_inner    <= n_inner;
            r_id_acc   <= n_id_acc;
            r_id_left  <= n_id_left;
            r_cap_op   <= n_cap_op;
            r_op_found <= n_op_found;
        end
    end

    always_comb begin
        n_outer    = r_outer;
        n_len_left = r_len_left;
        n_content  = r_content;
        n_tag_ok   = r_tag_ok;
        n_inner    = r_inner;
        n_id_acc   = r_id_acc;
        n_id_left  = r_id_left;
        n_cap_op   = r_cap_op;
        n_op_found = r_op_found;
        s_role     = ROLE_TAG;
        s_err      = ERR_NONE;
        s_last     = 1'b0;
        s_finish   = 1'b0;
        s_clear    = 1'b0;
        s_cnt      = r_in_byte[6:0];

        unique case (r_outer)
            OP_TAG: begin
                s_role   = ROLE_TAG;
                n_tag_ok = (r_in_byte == r_message_tag);
                s_clear  = 1'b1;
                n_outer  = OP_LEN0;
            end
            OP_LEN0: begin
                s_role = ROLE_LENGTH;
                if (!r_in_byte[7]) begin
                    n_content = CONTENT_W'(r_in_byte);
                    if (r_in_byte == '0) begin
                        s_finish = 1'b1;
                    end else begin
                        n_outer = OP_BODY;
                    end
                end else if (s_cnt == '0 || s_cnt > MAX_LEN_7) begin
                    // Indefinite or oversized length: drop the message.
                    s_err   = (s_cnt == '0) ? ERR_INDEFINITE : ERR_LEN_LONG;
                    s_last  = 1'b1;
                    s_clear = 1'b1;
                    n_outer = OP_TAG;
                end else begin
                    n_len_left = LW'(s_cnt);
                    n_content  = '0;
                    n_outer    = OP_LENX;
                end
            end
            OP_LENX: begin
                s_role     = ROLE_LENGTH;
                n_content  = {r_content[CONTENT_W-BYTE_W-1:0], r_in_byte};
                n_len_left = r_len_left - LW_ONE;
                if (n_len_left == '0) begin
                    if (n_content == '0) begin
                        s_finish = 1'b1;
                    end else begin
                        n_outer = OP_BODY;
                    end
                end
            end
            OP_BODY: begin
                s_role    = ROLE_CONTENT;
                n_content = r_content - CONTENT_W'(1);
                if (n_content == '0) begin
                    s_finish = 1'b1;
                end

                unique case (r_inner)
                    IP_ID_TAG: begin
                        n_inner = (r_in_byte == TAG_INTEGER) ? IP_ID_LEN0 : IP_IDLE;
                    end
                    IP_ID_LEN0: begin
                        if (!r_in_byte[7]) begin
                            n_id_acc = CONTENT_W'(r_in_byte);
                            n_inner  = (r_in_byte == '0) ? IP_OP_TAG : IP_ID_SKIP;
                        end else if (s_cnt == '0 || s_cnt > MAX_LEN_7) begin
                            n_inner = IP_IDLE;
                        end else begin
                            n_id_left = LW'(s_cnt);
                            n_id_acc  = '0;
                            n_inner   = IP_ID_LENX;
                        end
                    end
                    IP_ID_LENX: begin
                        n_id_acc  = {r_id_acc[CONTENT_W-BYTE_W-1:0], r_in_byte};
                        n_id_left = r_id_left - LW_ONE;
                        if (n_id_left == '0) begin
                            n_inner = (n_id_acc == '0) ? IP_OP_TAG : IP_ID_SKIP;
                        end
                    end
                    IP_ID_SKIP: begin
                        n_id_acc = r_id_acc - CONTENT_W'(1);
                        if (n_id_acc == '0) begin
                            n_inner = IP_OP_TAG;
                        end
                    end
                    IP_OP_TAG: begin
                        n_cap_op   = r_in_byte;
                        n_op_found = 1'b1;
                        n_inner    = IP_IDLE;
                    end
                    default: begin
                        n_inner = IP_IDLE;
                    end
                endcase
            end
            default: begin
            end
        endcase

        // Message summary, taken after this byte's inner update.
        s_op_valid = s_finish && n_op_found;
        s_op_tag   = s_op_valid ? n_cap_op : '0;
        s_done     = s_op_valid && n_tag_ok && (n_cap_op == r_done_tag);

        if (s_finish) begin
            s_last  = 1'b1;
            s_clear = 1'b1;
            n_outer = OP_TAG;
        end

        if (s_clear) begin
            n_inner    = IP_ID_TAG;
            n_id_acc   = '0;
            n_id_left  = '0;
            n_cap_op   = '0;
            n_op_found = 1'b0;
        end
    end

    // Result register.
    logic [BYTE_W-1:0] r_echo;
    t_byte_role        r_role;
    logic              r_last;
    logic [BYTE_W-1:0] r_op_tag;
    logic              r_op_valid;
    logic              r_done;
    t_error_code       r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_echo     <= r_in_byte;
            r_role     <= s_role;
            r_last     <= s_last;
            r_op_tag   <= s_op_tag;
            r_op_valid <= s_op_valid;
            r_done     <= s_done;
            r_err      <= s_err;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.echo_byte   = r_echo;
    assign o_res.byte_role   = r_role;
    assign o_res.frame_last  = r_last;
    assign o_res.op_tag      = r_op_tag;
    assign o_res.op_valid    = r_op_valid;
    assign o_res.search_done = r_done;
    assign o_res.error_code  = r_err;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the BER message deframer: directed rows, then random messages.
`timescale 1ns / 1ps

module tb_top;
    import bmd_pkg::*;

    localparam int unsigned MAX_LEN_BYTES = 4;

    // One result of the deframer, as it appears on the result channel.
    typedef struct {
        logic [BYTE_W-1:0] echo_byte;
        t_byte_role        byte_role;
        logic              frame_last;
        logic [BYTE_W-1:0] op_tag;
        logic              op_valid;
        logic              search_done;
        t_error_code       error_code;
    } t_deframe_result;

    // One row of the directed table. Where has_want is set, the result is typed in
    // by hand and replaces the predicted one in the expected queue.
    typedef struct {
        logic [BYTE_W-1:0] rx_byte;
        bit                has_want;
        t_deframe_result   want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bmd_rx_if  rx_ch ();
    bmd_res_if res_ch ();

    ber_message_deframer #(
        .MAX_LEN_BYTES(MAX_LEN_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers, updated when a write lands.
    logic [BYTE_W-1:0] cfg_message_tag = MESSAGE_TAG_RESET;
    logic [BYTE_W-1:0] cfg_done_tag    = DONE_TAG_RESET;

    // Predictor state: outer framing of the message.
    t_outer_phase   fr_phase     = OP_TAG;
    logic [2:0]     fr_len_bytes = '0;
    logic [31:0]    fr_remaining = '0;
    logic           fr_tag_match = 1'b0;

    // Predictor state: tracking of the message ID and the operation tag inside the content.
    t_inner_phase   id_phase     = IP_ID_TAG;
    logic [31:0]    id_count     = '0;
    logic [2:0]     id_len_bytes = '0;
    logic [7:0]     op_capture   = '0;
    logic           op_seen      = 1'b0;

    t_deframe_result expected_results [$];
    int unsigned     mismatches = 0;

    // Set by the sender together with each byte; read by the monitor when it is accepted.
    bit              row_typed = 1'b0;
    t_deframe_result row_want;

    bit              no_idle = 1'b0;
    int unsigned     sink_stall = 0;
    logic [7:0]      stream_q [$];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void id_clear();
        id_phase     = IP_ID_TAG;
        id_count     = '0;
        id_len_bytes = '0;
        op_capture   = '0;
        op_seen      = 1'b0;
    endfunction

    // Follows the message-ID INTEGER at the start of the content and grabs the byte after it.
    function automatic void id_track(logic [7:0] b);
        case (id_phase)
            IP_ID_TAG: begin
                id_phase = (b == TAG_INTEGER) ? IP_ID_LEN0 : IP_IDLE;
            end
            IP_ID_LEN0: begin
                if (!b[7]) begin
                    id_count = {24'd0, b};
                    id_phase = (b == 8'd0) ? IP_OP_TAG : IP_ID_SKIP;
                end else if (b[6:0] == 7'd0 || b[6:0] > MAX_LEN_BYTES) begin
                    id_phase = IP_IDLE;
                end else begin
                    id_len_bytes = 3'(b[6:0]);
                    id_count     = '0;
                    id_phase     = IP_ID_LENX;
                end
            end
            IP_ID_LENX: begin
                id_count     = {id_count[23:0], b};
                id_len_bytes = id_len_bytes - 3'd1;
                if (id_len_bytes == 3'd0) begin
                    id_phase = (id_count == 32'd0) ? IP_OP_TAG : IP_ID_SKIP;
                end
            end
            IP_ID_SKIP: begin
                id_count = id_count - 32'd1;
                if (id_count == 32'd0) begin
                    id_phase = IP_OP_TAG;
                end
            end
            IP_OP_TAG: begin
                op_capture = b;
                op_seen    = 1'b1;
                id_phase   = IP_IDLE;
            end
            default: begin
                id_phase = IP_IDLE;
            end
        endcase
    endfunction

    // Advances the predictor by one received byte and returns the result it must produce.
    function automatic t_deframe_result deframe(logic [7:0] b);
        t_deframe_result r;
        bit              finish;
        r.echo_byte   = b;
        r.byte_role   = ROLE_TAG;
        r.frame_last  = 1'b0;
        r.op_tag      = '0;
        r.op_valid    = 1'b0;
        r.search_done = 1'b0;
        r.error_code  = ERR_NONE;
        finish        = 1'b0;
        case (fr_phase)
            OP_TAG: begin
                fr_tag_match = (b == cfg_message_tag);
                id_clear();
                fr_phase = OP_LEN0;
            end
            OP_LEN0: begin
                r.byte_role = ROLE_LENGTH;
                if (!b[7]) begin
                    fr_remaining = {24'd0, b};
                    if (b == 8'd0) finish = 1'b1;
                    else fr_phase = OP_BODY;
                end else if (b[6:0] == 7'd0) begin
                    // Indefinite length is not supported: report it and resync on a tag.
                    r.error_code = ERR_INDEFINITE;
                    r.frame_last = 1'b1;
                    fr_phase     = OP_TAG;
                    id_clear();
                end else if (b[6:0] > MAX_LEN_BYTES) begin
                    r.error_code = ERR_LEN_LONG;
                    r.frame_last = 1'b1;
                    fr_phase     = OP_TAG;
                    id_clear();
                end else begin
                    fr_len_bytes = 3'(b[6:0]);
                    fr_remaining = '0;
                    fr_phase     = OP_LENX;
                end
            end
            OP_LENX: begin
                r.byte_role  = ROLE_LENGTH;
                fr_remaining = {fr_remaining[23:0], b};
                fr_len_bytes = fr_len_bytes - 3'd1;
                if (fr_len_bytes == 3'd0) begin
                    if (fr_remaining == 32'd0) finish = 1'b1;
                    else fr_phase = OP_BODY;
                end
            end
            default: begin
                r.byte_role = ROLE_CONTENT;
                id_track(b);
                fr_remaining = fr_remaining - 32'd1;
                if (fr_remaining == 32'd0) finish = 1'b1;
            end
        endcase
        if (finish) begin
            r.frame_last  = 1'b1;
            r.op_valid    = op_seen;
            r.op_tag      = op_seen ? op_capture : 8'd0;
            r.search_done = fr_tag_match && op_seen && (op_capture == cfg_done_tag);
            fr_phase      = OP_TAG;
            id_clear();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Both channels are sampled at the rising edge, where the DUT sees the same values.
    // Each accepted byte queues its expected result; each accepted result is compared
    // field by field against the oldest one.
    always @(posedge i_clk) begin : monitor
        t_deframe_result pred;
        t_deframe_result want;
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                pred = deframe(rx_ch.rx_byte);
                expected_results = {expected_results, row_typed ? row_want : pred};
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expected result, echo_byte 0x%0h",
                           res_ch.echo_byte);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("echo_byte", want.echo_byte, res_ch.echo_byte);
                    check_field("byte_role", 8'(want.byte_role), 8'(res_ch.byte_role));
                    check_field("frame_last", 8'(want.frame_last), 8'(res_ch.frame_last));
                    check_field("op_tag", want.op_tag, res_ch.op_tag);
                    check_field("op_valid", 8'(want.op_valid), 8'(res_ch.op_valid));
                    check_field("search_done", 8'(want.search_done), 8'(res_ch.search_done));
                    check_field("error_code", 8'(want.error_code), 8'(res_ch.error_code));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Idling on both sides
    // ------------------------------------------------------------------

    // Mostly no gap or a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // The result sink drops ready for random stretches, except during a burst phase.
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            res_ch.ready <= 1'b0;
            sink_stall   <= sink_stall - 1;
        end else begin
            res_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                sink_stall <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_deframe_result deframe_blank(logic [7:0] b);
        t_deframe_result r;
        r.echo_byte   = b;
        r.byte_role   = ROLE_TAG;
        r.frame_last  = 1'b0;
        r.op_tag      = '0;
        r.op_valid    = 1'b0;
        r.search_done = 1'b0;
        r.error_code  = ERR_NONE;
        return r;
    endfunction

    function automatic t_stim_row plain_row(logic [7:0] b);
        t_stim_row row;
        row.rx_byte  = b;
        row.has_want = 1'b0;
        row.want     = deframe_blank(b);
        return row;
    endfunction

    function automatic t_stim_row typed_row(logic [7:0] b, t_byte_role role, logic last,
                                            logic [7:0] tag, logic valid, logic done,
                                            t_error_code err);
        t_stim_row row;
        row.rx_byte          = b;
        row.has_want         = 1'b1;
        row.want             = deframe_blank(b);
        row.want.byte_role   = role;
        row.want.frame_last  = last;
        row.want.op_tag      = tag;
        row.want.op_valid    = valid;
        row.want.search_done = done;
        row.want.error_code  = err;
        return row;
    endfunction

    // Offers one byte after a random gap and returns at the edge where it is accepted.
    // Valid stays high afterwards; the next call either replaces the byte or drops valid.
    task automatic send_byte(input t_stim_row row);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= row.rx_byte;
        row_typed = row.has_want;
        row_want  = row.want;
        do @(posedge i_clk); while (!rx_ch.ready);
    endtask

    // Stops sending and waits until every expected result has come.
    task automatic wait_drained();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        if (idx == CFG_MESSAGE_TAG) cfg_message_tag = value;
        else cfg_done_tag = value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Appends one message to the stream. Most are well formed with a message ID and an
    // operation tag; others have a bad outer length, a bad or missing ID or a cut content.
    // Lengths are always chosen here, so no stray byte can open a huge message.
    function automatic void queue_message(bit big);
        logic [7:0]  body [$];
        int unsigned kind;
        int unsigned id_len;
        int unsigned n;
        int unsigned len;
        int unsigned keep;
        int unsigned r;
        logic [7:0]  tag;
        kind = $urandom_range(0, 99);
        tag  = ($urandom_range(0, 3) != 0) ? cfg_message_tag : 8'($urandom);
        stream_q = {stream_q, tag};
        if (kind < 12) begin
            // Outer length that the block must reject.
            if ($urandom_range(0, 1) == 0) stream_q = {stream_q, 8'h80};
            else stream_q = {stream_q,
                             8'h80 | 8'($urandom_range(MAX_LEN_BYTES + 1, 127))};
            return;
        end
        if (kind < 80) begin
            body = {body, TAG_INTEGER};
            id_len = $urandom_range(0, 3);
            r      = $urandom_range(0, 9);
            if (r < 6) begin
                body = {body, 8'(id_len)};
            end else if (r < 9) begin
                n = $urandom_range(1, MAX_LEN_BYTES);
                body = {body, 8'h80 | 8'(n)};
                for (int i = int'(n) - 1; i >= 0; i--) body = {body, 8'(id_len >> (8 * i))};
            end else if ($urandom_range(0, 1) == 0) begin
                body = {body, 8'h80};
            end else begin
                body = {body, 8'h80 | 8'($urandom_range(MAX_LEN_BYTES + 1, 127))};
            end
            repeat (id_len) body = {body, 8'($urandom)};
            body = {body, ($urandom_range(0, 1) == 0) ? cfg_done_tag : 8'($urandom)};
        end else begin
            // Content that does not open with a proper message ID.
            body = {body, 8'($urandom)};
        end
        repeat ($urandom_range(0, 4)) body = {body, 8'($urandom)};
        if (big) repeat (200) body = {body, 8'($urandom)};
        // Now and then the content is cut short.
        if (body.size() > 0 && $urandom_range(0, 9) == 0) begin
            keep = $urandom_range(0, body.size() - 1);
            while (body.size() > keep) void'(body.pop_back());
        end
        len = body.size();
        if (len < 128 && $urandom_range(0, 2) != 0) begin
            stream_q = {stream_q, 8'(len)};
        end else begin
            n = $urandom_range((len < 256) ? 1 : 2, MAX_LEN_BYTES);
            stream_q = {stream_q, 8'h80 | 8'(n)};
            for (int i = int'(n) - 1; i >= 0; i--) stream_q = {stream_q, 8'(len >> (8 * i))};
        end
        foreach (body[i]) stream_q = {stream_q, body[i]};
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        t_stim_row directed [$];
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MESSAGE_TAG;
        cfg_data      = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, run with the reset tags (0x30 outer, 0x65 done).
        // Empty content right after reset.
        directed = {directed, typed_row(8'h30, ROLE_TAG, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE)};
        directed = {directed, typed_row(8'h00, ROLE_LENGTH, 1'b1, 8'h00, 1'b0, 1'b0,
                                        ERR_NONE)};
        // Indefinite length, then a length field with too many bytes.
        directed = {directed, typed_row(8'h30, ROLE_TAG, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE)};
        directed = {directed, typed_row(8'h80, ROLE_LENGTH, 1'b1, 8'h00, 1'b0, 1'b0,
                                        ERR_INDEFINITE)};
        directed = {directed, typed_row(8'hFF, ROLE_TAG, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE)};
        directed = {directed, typed_row(8'h85, ROLE_LENGTH, 1'b1, 8'h00, 1'b0, 1'b0,
                                        ERR_LEN_LONG)};
        // The final search result message: search_done on its last byte.
        directed = {directed, typed_row(8'h30, ROLE_TAG, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE)};
        directed = {directed, typed_row(8'h05, ROLE_LENGTH, 1'b0, 8'h00, 1'b0, 1'b0,
                                        ERR_NONE)};
        directed = {directed, plain_row(8'h02)};
        directed = {directed, plain_row(8'h01)};
        directed = {directed, plain_row(8'h05)};
        directed = {directed, plain_row(8'h65)};
        directed = {directed, typed_row(8'h00, ROLE_CONTENT, 1'b1, 8'h65, 1'b1, 1'b1,
                                        ERR_NONE)};
        // Wrong outer tag with a long-form length and an empty ID: tag reported, no done.
        directed = {directed, plain_row(8'hFF)};
        directed = {directed, plain_row(8'h81)};
        directed = {directed, plain_row(8'h03)};
        directed = {directed, plain_row(8'h02)};
        directed = {directed, plain_row(8'h00)};
        directed = {directed, typed_row(8'h65, ROLE_CONTENT, 1'b1, 8'h65, 1'b1, 1'b0,
                                        ERR_NONE)};
        // Content that does not start with an INTEGER: no operation tag.
        directed = {directed, plain_row(8'h30)};
        directed = {directed, plain_row(8'h02)};
        directed = {directed, plain_row(8'h7F)};
        directed = {directed, typed_row(8'h65, ROLE_CONTENT, 1'b1, 8'h00, 1'b0, 1'b0,
                                        ERR_NONE)};
        // Content that ends inside the message ID value.
        directed = {directed, plain_row(8'h30)};
        directed = {directed, plain_row(8'h03)};
        directed = {directed, plain_row(8'h02)};
        directed = {directed, plain_row(8'h01)};
        directed = {directed, typed_row(8'hAA, ROLE_CONTENT, 1'b1, 8'h00, 1'b0, 1'b0,
                                        ERR_NONE)};
        foreach (directed[i]) send_byte(directed[i]);
        wait_drained();

        // Random phases, each under its own pair of tags. The registers are only
        // written once the previous phase has fully drained.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_cfg(CFG_MESSAGE_TAG, MESSAGE_TAG_RESET);
                    write_cfg(CFG_DONE_TAG, DONE_TAG_RESET);
                end
                1: begin
                    write_cfg(CFG_MESSAGE_TAG, 8'h00);
                    write_cfg(CFG_DONE_TAG, 8'h00);
                end
                2: begin
                    write_cfg(CFG_MESSAGE_TAG, 8'hFF);
                    write_cfg(CFG_DONE_TAG, 8'hFF);
                end
                default: begin
                    write_cfg(CFG_MESSAGE_TAG, 8'($urandom));
                    write_cfg(CFG_DONE_TAG, 8'($urandom));
                end
            endcase
            // One phase runs back to back with no idling on either side.
            no_idle = (phase == 3);
            stream_q.delete();
            if (phase == 4) queue_message(1'b1);
            while (stream_q.size() < 115) queue_message(1'b0);
            foreach (stream_q[i]) begin
                // Halfway through one phase the sender holds off until all results are in.
                if (phase == 1 && i == stream_q.size() / 2) wait_drained();
                send_byte(plain_row(stream_q[i]));
            end
            no_idle = 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
